// ----- rtl/lcdws_pkg.sv -----
package lcdws_pkg;

    localparam int MAX_CHARS   = 40;
    localparam int CHAR_IDX_W  = 7;
    localparam int MAX_WRITES  = 4;
    localparam int WR_IDX_W    = $clog2(MAX_WRITES);
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int PADDR_W     = 4;
    localparam int PDATA_W     = 32;
    localparam int WAIT_W      = 13;

    localparam logic [2:0] CMD_TEXT  = 3'd0;
    localparam logic [2:0] CMD_INSTR = 3'd1;
    localparam logic [2:0] CMD_DATA  = 3'd2;
    localparam logic [2:0] CMD_CLEAR = 3'd3;
    localparam logic [2:0] CMD_HOME  = 3'd4;
    localparam logic [2:0] CMD_INIT  = 3'd5;

    localparam logic [1:0] REG_CHARS_PER_LINE = 2'd0;
    localparam logic [1:0] REG_LINE_COUNT     = 2'd1;
    localparam logic [1:0] REG_SHORT_WAIT     = 2'd2;
    localparam logic [1:0] REG_LONG_WAIT      = 2'd3;

    localparam logic RS_INSTR = 1'b0;
    localparam logic RS_DATA  = 1'b1;

    localparam logic [7:0] BYTE_ENTRY_MODE = 8'h06;
    localparam logic [7:0] BYTE_LINE2      = 8'hC0;
    localparam logic [7:0] BYTE_FUNC_SET   = 8'h3C;
    localparam logic [7:0] BYTE_DISP_ON    = 8'h0C;
    localparam logic [7:0] BYTE_CLEAR      = 8'h01;
    localparam logic [7:0] BYTE_HOME       = 8'h02;
    localparam logic [7:0] BYTE_SPACE      = 8'h20;
    localparam logic [7:0] BYTE_DEL        = 8'h7F;

    localparam logic [1:0] TWO_LINES = 2'd2;

    typedef struct packed {
        logic [2:0] cmd;
        logic [7:0] byte_value;
        logic       end_of_text;
    } in_item_t;

    typedef struct packed {
        logic              reg_select;
        logic [7:0]        bus_byte;
        logic [WAIT_W-1:0] wait_after_us;
        logic              last_write;
    } out_item_t;

    typedef struct packed {
        logic [5:0]  chars_per_line;
        logic [1:0]  line_count;
        logic [9:0]  short_wait_us;
        logic [11:0] long_wait_us;
    } cfg_t;

    typedef struct packed {
        logic       rs;
        logic [7:0] data;
        logic       long_wait;
    } wr_t;

    typedef struct packed {
        wr_t [MAX_WRITES-1:0] writes;
        logic [WR_IDX_W-1:0]  last_idx;
    } plan_t;

    typedef struct packed {
        logic  push;
        plan_t plan;
    } q_wr_t;

    typedef struct packed {
        logic  full;
        logic  empty;
        plan_t head;
    } q_stat_t;

endpackage

// ----- rtl/lcdws_front.sv -----
module lcdws_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  lcdws_pkg::in_item_t s_item,
    input  lcdws_pkg::cfg_t     cfg,
    input  logic                q_full,
    output lcdws_pkg::q_wr_t    q_wr
);
    import lcdws_pkg::*;

    logic [CHAR_IDX_W-1:0] char_index_reg, char_index_next;
    logic                  in_text_reg, in_text_next;
    logic                  accept;
    logic                  has_write;
    logic [WR_IDX_W:0]     n;
    logic [7:0]            ch;
    plan_t                 plan;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;

    always_comb begin
        plan            = '0;
        n               = '0;
        has_write       = 1'b0;
        char_index_next = char_index_reg;
        in_text_next    = in_text_reg;
        ch = (s_item.byte_value >= BYTE_SPACE && s_item.byte_value < BYTE_DEL) ?
             s_item.byte_value : BYTE_SPACE;
        case (s_item.cmd)
            CMD_TEXT: begin
                if (char_index_reg < CHAR_IDX_W'(MAX_CHARS)) begin
                    if (!in_text_reg) begin
                        plan.writes[n[WR_IDX_W-1:0]] = '{RS_INSTR, BYTE_ENTRY_MODE, 1'b0};
                        n = n + 1'b1;
                        plan.writes[n[WR_IDX_W-1:0]] = '{RS_INSTR, BYTE_HOME, 1'b1};
                        n = n + 1'b1;
                    end
                    if (char_index_reg == CHAR_IDX_W'(cfg.chars_per_line) &&
                        cfg.line_count == TWO_LINES) begin
                        plan.writes[n[WR_IDX_W-1:0]] = '{RS_INSTR, BYTE_LINE2, 1'b0};
                        n = n + 1'b1;
                    end
                    plan.writes[n[WR_IDX_W-1:0]] = '{RS_DATA, ch, 1'b0};
                    n = n + 1'b1;
                    has_write       = 1'b1;
                    char_index_next = char_index_reg + 1'b1;
                end
                in_text_next = 1'b1;
                if (s_item.end_of_text) begin
                    in_text_next    = 1'b0;
                    char_index_next = '0;
                end
            end
            CMD_INSTR, CMD_DATA, CMD_CLEAR, CMD_HOME: begin
                case (s_item.cmd)
                    CMD_INSTR: plan.writes[0] = '{RS_INSTR, s_item.byte_value, 1'b0};
                    CMD_DATA:  plan.writes[0] = '{RS_DATA, s_item.byte_value, 1'b0};
                    CMD_CLEAR: plan.writes[0] = '{RS_INSTR, BYTE_CLEAR, 1'b1};
                    default:   plan.writes[0] = '{RS_INSTR, BYTE_HOME, 1'b1};
                endcase
                n               = (WR_IDX_W+1)'(1);
                has_write       = 1'b1;
                in_text_next    = 1'b0;
                char_index_next = '0;
            end
            CMD_INIT: begin
                plan.writes[0]  = '{RS_INSTR, BYTE_FUNC_SET, 1'b0};
                plan.writes[1]  = '{RS_INSTR, BYTE_DISP_ON, 1'b0};
                plan.writes[2]  = '{RS_INSTR, BYTE_CLEAR, 1'b1};
                plan.writes[3]  = '{RS_INSTR, BYTE_ENTRY_MODE, 1'b0};
                n               = (WR_IDX_W+1)'(MAX_WRITES);
                has_write       = 1'b1;
                in_text_next    = 1'b0;
                char_index_next = '0;
            end
            default: begin
                has_write = 1'b0;
            end
        endcase
        plan.last_idx = WR_IDX_W'(n - 1'b1);
    end

    assign q_wr.push = accept && has_write;
    assign q_wr.plan = plan;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            char_index_reg <= '0;
            in_text_reg    <= 1'b0;
        end else if (accept) begin
            char_index_reg <= char_index_next;
            in_text_reg    <= in_text_next;
        end
    end

endmodule

// ----- rtl/lcdws_queue.sv -----
module lcdws_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  lcdws_pkg::q_wr_t    q_wr,
    input  logic                pop,
    output lcdws_pkg::q_stat_t  q_stat
);
    import lcdws_pkg::*;

    plan_t             mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              do_push, do_pop;

    assign q_stat.full  = count_reg == QCNT_W'(QUEUE_DEPTH);
    assign q_stat.empty = count_reg == '0;
    assign q_stat.head  = mem_reg[rd_ptr_reg];

    assign do_push = q_wr.push && !q_stat.full;
    assign do_pop  = pop && !q_stat.empty;

    always_comb begin
        count_next = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= q_wr.plan;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

endmodule

// ----- rtl/lcdws_back.sv -----
module lcdws_back (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  lcdws_pkg::q_stat_t   q_stat,
    output logic                 pop,
    input  lcdws_pkg::cfg_t      cfg,
    output logic                 m_valid,
    input  logic                 m_ready,
    output lcdws_pkg::out_item_t m_item
);
    import lcdws_pkg::*;

    logic [WR_IDX_W-1:0] step_reg, step_next;
    logic                m_valid_reg, m_valid_next;
    out_item_t           m_item_reg, m_item_next;
    logic                load;
    logic                last;
    wr_t                 wr;

    assign load = !q_stat.empty && (!m_valid_reg || m_ready);
    assign wr   = q_stat.head.writes[step_reg];
    assign last = step_reg == q_stat.head.last_idx;
    assign pop  = load && last;

    always_comb begin
        step_next    = step_reg;
        m_valid_next = m_valid_reg;
        m_item_next  = m_item_reg;
        if (m_ready) begin
            m_valid_next = 1'b0;
        end
        if (load) begin
            m_valid_next              = 1'b1;
            m_item_next.reg_select    = wr.rs;
            m_item_next.bus_byte      = wr.data;
            m_item_next.wait_after_us = WAIT_W'(cfg.short_wait_us) +
                                        (wr.long_wait ? WAIT_W'(cfg.long_wait_us) : '0);
            m_item_next.last_write    = last;
            step_next                 = last ? '0 : step_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            step_reg    <= step_next;
            m_valid_reg <= m_valid_next;
        end
        m_item_reg <= m_item_next;
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

endmodule

// ----- rtl/char_lcd_write_sequencer.sv -----
// Channel  | Ports                          | Carries
// ---------+--------------------------------+------------------------------------
// input    | s_valid, s_ready, s_item       | one command item
// result   | m_valid, m_ready, m_item       | one bus write per item
// config   | psel, penable, pwrite, paddr,  | four registers at byte 0, 4, 8, 12
//          | pwdata, prdata, pready         |
//
// A command yields zero to four bus writes, issued one per cycle from the result register
// while the result port accepts them; a text character yields up to four writes (none when
// dropped), init four, undefined commands none, the others one.
// The front classifies and accepts one item per cycle while the four-entry plan queue has room.
// Reset clears the text state, the queue and the output valid flag; registers go to defaults.
// A stalled result port holds the output; the front keeps accepting until the queue fills.
module char_lcd_write_sequencer (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  lcdws_pkg::in_item_t                 s_item,
    output logic                                m_valid,
    input  logic                                m_ready,
    output lcdws_pkg::out_item_t                m_item,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [lcdws_pkg::PADDR_W-1:0]       paddr,
    input  logic [lcdws_pkg::PDATA_W-1:0]       pwdata,
    output logic [lcdws_pkg::PDATA_W-1:0]       prdata,
    output logic                                pready
);
    import lcdws_pkg::*;

    cfg_t       cfg_reg;
    logic       cfg_wr;
    logic [1:0] reg_idx;
    q_wr_t      q_wr;
    q_stat_t    q_stat;
    logic       pop;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_idx = paddr[3:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.chars_per_line <= 6'd20;
            cfg_reg.line_count     <= 2'd2;
            cfg_reg.short_wait_us  <= 10'd45;
            cfg_reg.long_wait_us   <= 12'd1600;
        end else if (cfg_wr) begin
            case (reg_idx)
                REG_CHARS_PER_LINE: cfg_reg.chars_per_line <= pwdata[5:0];
                REG_LINE_COUNT:     cfg_reg.line_count     <= pwdata[1:0];
                REG_SHORT_WAIT:     cfg_reg.short_wait_us  <= pwdata[9:0];
                REG_LONG_WAIT:      cfg_reg.long_wait_us   <= pwdata[11:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_CHARS_PER_LINE: prdata = PDATA_W'(cfg_reg.chars_per_line);
            REG_LINE_COUNT:     prdata = PDATA_W'(cfg_reg.line_count);
            REG_SHORT_WAIT:     prdata = PDATA_W'(cfg_reg.short_wait_us);
            REG_LONG_WAIT:      prdata = PDATA_W'(cfg_reg.long_wait_us);
            default:            prdata = '0;
        endcase
    end

    lcdws_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .cfg     (cfg_reg),
        .q_full  (q_stat.full),
        .q_wr    (q_wr)
    );

    lcdws_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_wr    (q_wr),
        .pop     (pop),
        .q_stat  (q_stat)
    );

    lcdws_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_stat  (q_stat),
        .pop     (pop),
        .cfg     (cfg_reg),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

endmodule

// ----- dv/tb_top.sv -----
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import lcdws_pkg::*;

    localparam logic [2:0] CMD_UNDEF_LO = 3'd6;
    localparam logic [2:0] CMD_UNDEF_HI = 3'd7;
    localparam int DRAIN_CYCLES    = 40;
    localparam int REPORT_LIMIT    = 10;
    localparam int RANDOM_PHASES   = 6;
    localparam int ITEMS_PER_PHASE = 60;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int TIMEOUT_NS      = 2_000_000;

    typedef enum int {
        READY_ALWAYS,
        READY_RANDOM,
        READY_PATTERN,
        READY_SPARSE
    } ready_mode_e;

    logic                aclk;
    logic                aresetn;
    logic                s_valid;
    logic                s_ready;
    in_item_t            s_item;
    logic                m_valid;
    logic                m_ready = 1'b0;
    out_item_t           m_item;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [PADDR_W-1:0]  paddr;
    logic [PDATA_W-1:0]  pwdata;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;

    // register shadow and text state of the predictor
    logic [5:0]            cpl_q   = 6'd20;
    logic [1:0]            lines_q = 2'd2;
    logic [9:0]            short_q = 10'd45;
    logic [11:0]           long_q  = 12'd1600;
    logic [CHAR_IDX_W-1:0] char_idx_q = '0;
    logic                  in_text_q  = 1'b0;

    out_item_t   staged_writes[$];
    out_item_t   bus_writes_due[$];
    int          mismatches = 0;
    int          productive_items = 0;

    ready_mode_e ready_mode = READY_ALWAYS;
    logic [15:0] ready_pat = 16'b1110_0110_1011_0001;
    int          hold_off_cycles = 0;
    int          gap_max = 0;
    int          burst_max = 1;
    int          burst_left = 0;

    char_lcd_write_sequencer i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("char_lcd_write_sequencer regression: fail");
        $finish;
    end

    function automatic void stage_write(input logic rs, input logic [7:0] data,
                                        input logic long_wait);
        out_item_t w;
        w.reg_select    = rs;
        w.bus_byte      = data;
        w.wait_after_us = WAIT_W'(short_q);
        if (long_wait) w.wait_after_us = w.wait_after_us + WAIT_W'(long_q);
        w.last_write    = 1'b0;
        staged_writes.push_back(w);
    endfunction

    // Work out the bus writes of one command, update the text state, queue them.
    function automatic int plan_bus_writes(input in_item_t it);
        logic [7:0] shown;
        out_item_t  w;
        staged_writes.delete();
        case (it.cmd)
            CMD_TEXT: begin
                if (char_idx_q < MAX_CHARS) begin
                    shown = (it.byte_value >= BYTE_SPACE && it.byte_value < BYTE_DEL) ?
                            it.byte_value : BYTE_SPACE;
                    if (!in_text_q) begin
                        stage_write(RS_INSTR, BYTE_ENTRY_MODE, 1'b0);
                        stage_write(RS_INSTR, BYTE_HOME, 1'b1);
                    end
                    if (char_idx_q == {1'b0, cpl_q} && lines_q == TWO_LINES)
                        stage_write(RS_INSTR, BYTE_LINE2, 1'b0);
                    stage_write(RS_DATA, shown, 1'b0);
                    char_idx_q = char_idx_q + 1'b1;
                end
                in_text_q = 1'b1;
                if (it.end_of_text) begin
                    in_text_q  = 1'b0;
                    char_idx_q = '0;
                end
            end
            CMD_INSTR, CMD_DATA, CMD_CLEAR, CMD_HOME, CMD_INIT: begin
                case (it.cmd)
                    CMD_INSTR: stage_write(RS_INSTR, it.byte_value, 1'b0);
                    CMD_DATA:  stage_write(RS_DATA, it.byte_value, 1'b0);
                    CMD_CLEAR: stage_write(RS_INSTR, BYTE_CLEAR, 1'b1);
                    CMD_HOME:  stage_write(RS_INSTR, BYTE_HOME, 1'b1);
                    default: begin
                        stage_write(RS_INSTR, BYTE_FUNC_SET, 1'b0);
                        stage_write(RS_INSTR, BYTE_DISP_ON, 1'b0);
                        stage_write(RS_INSTR, BYTE_CLEAR, 1'b1);
                        stage_write(RS_INSTR, BYTE_ENTRY_MODE, 1'b0);
                    end
                endcase
                in_text_q  = 1'b0;
                char_idx_q = '0;
            end
            default: begin
            end
        endcase
        for (int i = 0; i < staged_writes.size(); i++) begin
            w = staged_writes[i];
            w.last_write = (i == staged_writes.size() - 1);
            bus_writes_due.push_back(w);
        end
        return staged_writes.size();
    endfunction

    task automatic check_bus_write(input out_item_t got);
        out_item_t want;
        if (bus_writes_due.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
                $display("unexpected bus write: rs=%0d byte=%02h wait=%0d last=%0d",
                         got.reg_select, got.bus_byte, got.wait_after_us, got.last_write);
        end else begin
            want = bus_writes_due.pop_front();
            if (got.reg_select !== want.reg_select || got.bus_byte !== want.bus_byte ||
                got.wait_after_us !== want.wait_after_us ||
                got.last_write !== want.last_write) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("bus write mismatch: expected rs=%0d byte=%02h wait=%0d last=%0d",
                             want.reg_select, want.bus_byte, want.wait_after_us,
                             want.last_write,
                             ", got rs=%0d byte=%02h wait=%0d last=%0d",
                             got.reg_select, got.bus_byte,
                             got.wait_after_us, got.last_write);
            end
        end
    endtask

    // Result side: check each accepted write, then pick the next ready value.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) check_bus_write(m_item);
        if (hold_off_cycles > 0) begin
            m_ready <= 1'b0;
            hold_off_cycles--;
        end else begin
            case (ready_mode)
                READY_RANDOM: m_ready <= ($urandom_range(3) != 0);
                READY_PATTERN: begin
                    m_ready   <= ready_pat[15];
                    ready_pat <= {ready_pat[14:0], ready_pat[15]};
                end
                READY_SPARSE: m_ready <= ($urandom_range(3) == 0);
                default: m_ready <= 1'b1;
            endcase
        end
    end

    task automatic send_item(input in_item_t it);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, burst_max);
            gap = (gap_max > 0) ? $urandom_range(0, gap_max) : 0;
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_valid <= 1'b1;
        s_item  <= it;
        do @(posedge aclk); while (!s_ready);
        if (plan_bus_writes(it) > 0) productive_items++;
    endtask

    task automatic send_cmd(input logic [2:0] cmd, input logic [7:0] value, input logic eot);
        in_item_t it;
        it.cmd         = cmd;
        it.byte_value  = value;
        it.end_of_text = eot;
        send_item(it);
    endtask

    task automatic send_string(input int len, input bit random_chars, input bit end_it);
        logic [7:0] ch;
        for (int i = 0; i < len; i++) begin
            if (!random_chars)
                ch = 8'h61 + 8'(i % 26);
            else if ($urandom_range(3) == 0)
                ch = 8'($urandom_range(255));
            else
                ch = 8'($urandom_range(BYTE_SPACE, BYTE_DEL - 1));
            send_cmd(CMD_TEXT, ch, end_it && (i == len - 1));
        end
    endtask

    // Drop valid, wait for every write to come out, then let stragglers drain.
    task automatic wait_idle();
        s_valid <= 1'b0;
        burst_left = 0;
        while (bus_writes_due.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic apb_write(input logic [1:0] reg_idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (reg_idx)
            REG_CHARS_PER_LINE: cpl_q   = value[5:0];
            REG_LINE_COUNT:     lines_q = value[1:0];
            REG_SHORT_WAIT:     short_q = value[9:0];
            default:            long_q  = value[11:0];
        endcase
    endtask

    task automatic set_config(input int cpl, input int lines, input int short_us,
                              input int long_us);
        wait_idle();
        apb_write(REG_CHARS_PER_LINE, 32'(cpl));
        apb_write(REG_LINE_COUNT, 32'(lines));
        apb_write(REG_SHORT_WAIT, 32'(short_us));
        apb_write(REG_LONG_WAIT, 32'(long_us));
    endtask

    // Reset defaults: every command, character range edges, string boundaries.
    task automatic test_commands_at_reset();
        ready_mode = READY_RANDOM;
        gap_max    = 3;
        burst_max  = 4;
        send_cmd(CMD_INIT, 8'h00, 1'b0);
        send_cmd(CMD_TEXT, 8'h41, 1'b0);
        send_cmd(CMD_TEXT, 8'h00, 1'b0);
        send_cmd(CMD_TEXT, 8'hFF, 1'b0);
        send_cmd(CMD_TEXT, 8'h1F, 1'b0);
        send_cmd(CMD_TEXT, 8'h20, 1'b0);
        send_cmd(CMD_TEXT, 8'h7E, 1'b0);
        send_cmd(CMD_TEXT, 8'h7F, 1'b0);
        send_cmd(CMD_TEXT, 8'h80, 1'b1);
        send_cmd(CMD_INSTR, 8'hFF, 1'b1);
        send_cmd(CMD_INSTR, 8'h00, 1'b0);
        send_cmd(CMD_DATA, 8'hFF, 1'b0);
        send_cmd(CMD_DATA, 8'h00, 1'b1);
        send_cmd(CMD_CLEAR, 8'hAA, 1'b0);
        send_cmd(CMD_HOME, 8'h55, 1'b1);
        // undefined commands must leave the open string alone
        send_cmd(CMD_TEXT, 8'h41, 1'b0);
        send_cmd(CMD_UNDEF_LO, 8'hFF, 1'b1);
        send_cmd(CMD_TEXT, 8'h42, 1'b0);
        send_cmd(CMD_UNDEF_HI, 8'h00, 1'b0);
        send_cmd(CMD_INSTR, 8'h0C, 1'b0);
        send_cmd(CMD_TEXT, 8'h43, 1'b1);
    endtask

    task automatic test_line_wrap_and_drop();
        ready_mode = READY_PATTERN;
        set_config(3, TWO_LINES, 0, 0);
        send_string(8, 1'b0, 1'b1);
        set_config(3, 1, 5, 7);
        send_string(6, 1'b0, 1'b1);
        set_config(0, TWO_LINES, 45, 1600);
        send_string(3, 1'b0, 1'b1);
        set_config(2, 3, 45, 1600);
        send_string(4, 1'b0, 1'b1);
        set_config(2, 0, 45, 1600);
        send_string(4, 1'b0, 1'b1);
        // jump on the last line slot, then drop past the limit; end marker still counts
        set_config(39, TWO_LINES, 45, 1600);
        send_string(43, 1'b0, 1'b1);
        send_string(2, 1'b0, 1'b1);
    endtask

    task automatic test_wait_extremes();
        ready_mode = READY_SPARSE;
        set_config(40, TWO_LINES, 1023, 4095);
        send_cmd(CMD_CLEAR, 8'h00, 1'b0);
        send_cmd(CMD_HOME, 8'h00, 1'b0);
        send_cmd(CMD_INIT, 8'h00, 1'b0);
        send_cmd(CMD_TEXT, 8'h5A, 1'b1);
        set_config(63, TWO_LINES, 0, 4095);
        send_cmd(CMD_INIT, 8'hFF, 1'b1);
        send_cmd(CMD_TEXT, 8'h7E, 1'b1);
    endtask

    // Hold the result side off while the sender keeps pushing back to back.
    task automatic test_queue_backpressure();
        set_config(20, TWO_LINES, 45, 1600);
        ready_mode = READY_ALWAYS;
        gap_max    = 0;
        burst_max  = 1;
        hold_off_cycles = HOLD_OFF_CYCLES;
        repeat (10) send_cmd(CMD_INIT, 8'h00, 1'b0);
        send_string(12, 1'b1, 1'b1);
    endtask

    task automatic test_random_traffic();
        int start;
        int pick;
        int len;
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            case (phase)
                0: set_config(20, TWO_LINES, 45, 1600);
                1: set_config(1, TWO_LINES, 0, 0);
                2: set_config(40, TWO_LINES, 1023, 4095);
                3: set_config(0, 1, $urandom_range(1023), $urandom_range(4095));
                default: set_config($urandom_range(63), $urandom_range(3),
                                    $urandom_range(1023), $urandom_range(4095));
            endcase
            ready_mode = ready_mode_e'(phase % 4);
            gap_max    = (phase == 2) ? 0 : $urandom_range(1, 6);
            burst_max  = $urandom_range(1, 12);
            start      = productive_items;
            while (productive_items - start < ITEMS_PER_PHASE) begin
                pick = $urandom_range(99);
                if (pick < 60) begin
                    len = $urandom_range(99);
                    if (len < 75)      len = $urandom_range(1, 12);
                    else if (len < 90) len = $urandom_range(13, 30);
                    else               len = $urandom_range(38, 48);
                    send_string(len, 1'b1, $urandom_range(9) != 0);
                end else if (pick < 85) begin
                    send_cmd(3'($urandom_range(CMD_INSTR, CMD_INIT)), 8'($urandom_range(255)),
                             1'($urandom_range(1)));
                end else if (pick < 92) begin
                    send_cmd(3'($urandom_range(CMD_UNDEF_LO, CMD_UNDEF_HI)),
                             8'($urandom_range(255)), 1'($urandom_range(1)));
                end else begin
                    send_cmd(CMD_TEXT, 8'($urandom_range(255)), 1'($urandom_range(1)));
                end
            end
        end
    endtask

    initial begin
        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_item  <= '0;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= '0;
        pwdata  <= '0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_commands_at_reset();
        test_line_wrap_and_drop();
        test_wait_extremes();
        test_queue_backpressure();
        test_random_traffic();
        wait_idle();

        if (mismatches == 0 && bus_writes_due.size() == 0) begin
            $display("char_lcd_write_sequencer regression: pass");
        end else begin
            $display("char_lcd_write_sequencer regression: fail");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/lcdws_pkg.sv
rtl/lcdws_front.sv
rtl/lcdws_queue.sv
rtl/lcdws_back.sv
rtl/char_lcd_write_sequencer.sv
dv/tb_top.sv
